/* hw/rtl/wmss_pkg.sv */
// Package: phase codes, result kinds and shared types for the module stream scanner.
`timescale 1ns / 1ps
package wmss_pkg;

  localparam int OffsetBitsDefault = 32;

  typedef enum logic [4:0] {
    PH_HDR         = 5'd0,
    PH_SEC_ID      = 5'd1,
    PH_SEC_SIZE    = 5'd2,
    PH_SKIP        = 5'd3,
    PH_CODE_COUNT  = 5'd4,
    PH_BODY_SIZE   = 5'd5,
    PH_BODY_SKIP   = 5'd6,
    PH_CNAME_LEN   = 5'd7,
    PH_CNAME_CHARS = 5'd8,
    PH_SUB_ID      = 5'd9,
    PH_SUB1_SIZE   = 5'd10,
    PH_SUBX_SIZE   = 5'd11,
    PH_SUBX_SKIP   = 5'd12,
    PH_FN_COUNT    = 5'd13,
    PH_ENTRY_IDX   = 5'd14,
    PH_ENTRY_LEN   = 5'd15,
    PH_ENTRY_TEXT  = 5'd16
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SECTION = 2'd0,
    KIND_BODY    = 2'd1,
    KIND_NAME    = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  localparam logic [7:0] SecCode   = 8'd10;
  localparam logic [7:0] SecCustom = 8'd0;
  localparam logic [7:0] SubFnames = 8'd1;
  localparam logic [7:0] ContBit   = 8'h80;

  // one result record as it travels through the queue
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  section_id;
    logic [31:0] start_offset;
    logic [31:0] item_length;
    logic [31:0] function_number;
    logic        name_found;
    logic        header_valid;
    logic        last_result;
  } result_t;

  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    case (idx)
      3'd1: header_byte = 8'h61;
      3'd2: header_byte = 8'h73;
      3'd3: header_byte = 8'h6d;
      3'd4: header_byte = 8'h01;
      default: header_byte = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] name_char(input logic [1:0] idx);
    case (idx)
      2'd0: name_char = 8'h6e;
      2'd1: name_char = 8'h61;
      2'd2: name_char = 8'h6d;
      default: name_char = 8'h65;
    endcase
  endfunction

endpackage

/* hw/rtl/wmss_front.sv */
// Front end: per-byte parser that turns each accepted byte into up to two results.
`timescale 1ns / 1ps
module wmss_front import wmss_pkg::*; #(
  parameter int OFFSET_BITS = OffsetBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        end_of_module,
  input  logic [31:0] wanted_function,
  output logic        res0_valid,
  output logic        res1_valid,
  output result_t     res0,
  output result_t     res1
);

  phase_t                 parse_phase, parse_phase_next;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [31:0]            leb_accumulator;
  logic [5:0]             leb_shift;
  logic [31:0]            section_remaining, subsection_remaining;
  logic [7:0]             current_section;
  logic [31:0]            body_ordinal, entry_index, skip_remaining;
  logic                   match_seen, header_good;

  logic [31:0] acc_next, sec_rem_next, sub_rem_next, ord_next, idx_next, skip_next;
  logic [5:0]  shift_next;
  logic [7:0]  cur_next;
  logic        match_next, hdr_next;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [31:0] pos_ext;
  logic [31:0] leb_val, leb_part;
  logic        leb_done, in_sec, in_sub;
  logic        ev_valid;
  result_t     ev;
  logic [63:0] shifted;

  assign pos_inc = byte_position + 1'b1;
  assign pos_ext = 32'(pos_inc);
  assign in_sec  = parse_phase >= PH_SKIP;
  assign in_sub  = parse_phase >= PH_SUBX_SKIP;
  assign shifted = {57'd0, data_byte[6:0]} << leb_shift;
  assign leb_part = (leb_shift < 6'd32) ? shifted[31:0] : 32'd0;
  assign leb_val  = leb_accumulator | leb_part;
  assign leb_done = !data_byte[7];

  always_comb begin
    result_t endr;
    parse_phase_next = parse_phase;
    acc_next   = leb_accumulator;
    shift_next = leb_shift;
    sec_rem_next = in_sec ? section_remaining - 1'b1 : section_remaining;
    sub_rem_next = in_sub ? subsection_remaining - 1'b1 : subsection_remaining;
    cur_next   = current_section;
    ord_next   = body_ordinal;
    idx_next   = entry_index;
    skip_next  = skip_remaining;
    match_next = match_seen;
    hdr_next   = header_good;
    ev_valid   = 1'b0;
    ev         = '0;
    endr       = '0;

    // shared LEB128 step for phases that read a number
    if (parse_phase == PH_SEC_SIZE || parse_phase == PH_CODE_COUNT ||
        parse_phase == PH_BODY_SIZE || parse_phase == PH_CNAME_LEN ||
        parse_phase == PH_SUB1_SIZE || parse_phase == PH_SUBX_SIZE ||
        parse_phase == PH_FN_COUNT || parse_phase == PH_ENTRY_IDX ||
        parse_phase == PH_ENTRY_LEN) begin
      if (leb_done) begin
        acc_next   = '0;
        shift_next = '0;
      end else begin
        acc_next = leb_val;
        if (leb_shift < 6'd35) shift_next = leb_shift + 6'd7;
      end
    end

    ev.section_id   = current_section;
    ev.start_offset = pos_ext;
    ev.item_length  = leb_val;

    unique case (parse_phase)
      PH_HDR: begin
        if (data_byte != header_byte(byte_position[2:0])) hdr_next = 1'b0;
        if (32'(byte_position) >= 32'd7) parse_phase_next = PH_SEC_ID;
      end
      PH_SEC_ID: begin
        cur_next = data_byte;
        parse_phase_next = PH_SEC_SIZE;
      end
      PH_SEC_SIZE: if (leb_done) begin
        sec_rem_next = leb_val;
        ev_valid = 1'b1;
        ev.kind  = KIND_SECTION;
        if (leb_val == '0) parse_phase_next = PH_SEC_ID;
        else if (current_section == SecCode) begin
          ord_next = '0;
          parse_phase_next = PH_CODE_COUNT;
        end else if (current_section == SecCustom) parse_phase_next = PH_CNAME_LEN;
        else parse_phase_next = PH_SKIP;
      end
      PH_SKIP: ;
      PH_CODE_COUNT: if (leb_done) parse_phase_next = PH_BODY_SIZE;
      PH_BODY_SIZE: if (leb_done) begin
        ev_valid = 1'b1;
        ev.kind  = KIND_BODY;
        ev.function_number = body_ordinal;
        ord_next  = body_ordinal + 1'b1;
        skip_next = leb_val;
        parse_phase_next = (leb_val != '0) ? PH_BODY_SKIP : PH_BODY_SIZE;
      end
      PH_BODY_SKIP: begin
        skip_next = skip_remaining - 1'b1;
        if (skip_next == '0) parse_phase_next = PH_BODY_SIZE;
      end
      PH_CNAME_LEN: if (leb_done) begin
        skip_next = '0;
        parse_phase_next = (leb_val == 32'd4) ? PH_CNAME_CHARS : PH_SKIP;
      end
      PH_CNAME_CHARS: begin
        if (data_byte != name_char(skip_remaining[1:0])) parse_phase_next = PH_SKIP;
        else begin
          skip_next = skip_remaining + 1'b1;
          if (skip_next >= 32'd4) parse_phase_next = PH_SUB_ID;
        end
      end
      PH_SUB_ID:
        parse_phase_next = (data_byte == SubFnames) ? PH_SUB1_SIZE : PH_SUBX_SIZE;
      PH_SUB1_SIZE: if (leb_done) begin
        sub_rem_next = leb_val;
        parse_phase_next = (leb_val != '0) ? PH_FN_COUNT : PH_SKIP;
      end
      PH_SUBX_SIZE: if (leb_done) begin
        sub_rem_next = leb_val;
        parse_phase_next = (leb_val != '0) ? PH_SUBX_SKIP : PH_SUB_ID;
      end
      PH_SUBX_SKIP: ;
      PH_FN_COUNT: if (leb_done) parse_phase_next = PH_ENTRY_IDX;
      PH_ENTRY_IDX: if (leb_done) begin
        idx_next = leb_val;
        parse_phase_next = PH_ENTRY_LEN;
      end
      PH_ENTRY_LEN: if (leb_done) begin
        if (!match_seen && entry_index == wanted_function) begin
          ev_valid = 1'b1;
          ev.kind  = KIND_NAME;
          ev.function_number = entry_index;
          match_next = 1'b1;
        end
        skip_next = leb_val;
        parse_phase_next = (leb_val != '0) ? PH_ENTRY_TEXT : PH_ENTRY_IDX;
      end
      PH_ENTRY_TEXT: begin
        skip_next = skip_remaining - 1'b1;
        if (skip_next == '0) parse_phase_next = PH_ENTRY_IDX;
      end
      default: ;
    endcase

    if (in_sub && sub_rem_next == '0) begin
      parse_phase_next = (parse_phase == PH_SUBX_SKIP) ? PH_SUB_ID : PH_SKIP;
      acc_next = '0;
      shift_next = '0;
    end
    if (in_sec && sec_rem_next == '0) begin
      parse_phase_next = PH_SEC_ID;
      acc_next = '0;
      shift_next = '0;
    end

    // end result, appended after any parse result
    endr.kind = KIND_END;
    endr.name_found   = match_next;
    endr.header_valid = hdr_next && (parse_phase_next != PH_HDR);
    endr.last_result  = 1'b1;
    ev.last_result    = !end_of_module;

    if (ev_valid) begin
      res0_valid = 1'b1;
      res0       = ev;
      res1_valid = end_of_module;
      res1       = endr;
    end else begin
      res0_valid = end_of_module;
      res0       = endr;
      res1_valid = 1'b0;
      res1       = endr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && end_of_module)) begin
      parse_phase          <= PH_HDR;
      byte_position        <= '0;
      leb_accumulator      <= '0;
      leb_shift            <= '0;
      section_remaining    <= '0;
      current_section      <= '0;
      subsection_remaining <= '0;
      body_ordinal         <= '0;
      entry_index          <= '0;
      skip_remaining       <= '0;
      match_seen           <= 1'b0;
      header_good          <= 1'b1;
    end else if (take) begin
      parse_phase          <= parse_phase_next;
      byte_position        <= pos_inc;
      leb_accumulator      <= acc_next;
      leb_shift            <= shift_next;
      section_remaining    <= sec_rem_next;
      current_section      <= cur_next;
      subsection_remaining <= sub_rem_next;
      body_ordinal         <= ord_next;
      entry_index          <= idx_next;
      skip_remaining       <= skip_next;
      match_seen           <= match_next;
      header_good          <= hdr_next;
    end
  end

endmodule

/* hw/rtl/wmss_queue.sv */
// Result queue: four-entry FIFO between parser and output, takes up to two results a cycle.
`timescale 1ns / 1ps
module wmss_queue import wmss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push0,
  input  logic    push1,
  input  result_t din0,
  input  result_t din1,
  output logic    room2,
  output logic    out_valid,
  output result_t dout,
  input  logic    out_ready
);

  result_t    mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 3'd0;
  assign dout      = mem[rd_ptr];
  // two free slots after this cycle's pop is not counted, keeps timing short
  assign room2     = count <= 3'd2;

  always_comb begin
    count_next = count + 3'(push0) + 3'(push1) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) mem[wr_ptr] <= din0;
    if (push1) mem[2'(wr_ptr + 2'd1)] <= din1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + 2'(push0) + 2'(push1);
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count_next;
    end
  end

endmodule

/* hw/rtl/wasm_module_stream_scanner_unit.sv */
// Top level of the WebAssembly module stream scanner.
`timescale 1ns / 1ps
//  channel   handshake                 payload
//  in        in_valid / in_ready       data_byte, end_of_module
//  out       out_valid / out_ready     kind .. last_result
//  cfg       cfg_we                    cfg_data (wanted_function)
//
// One byte per cycle while in_ready is high: the front parser decodes each byte
// combinationally and pushes its zero to two results into a four-entry queue;
// a result is registered there and offered on out_valid once it is at the head.
// in_ready is high while the queue has at least two free slots, so the output
// side may stall without losing results; input stalls once three or more
// results are waiting, and a pop in the same cycle does not lift the stall.
// rst is synchronous; the parser returns to reset state after each end result.
module wasm_module_stream_scanner_unit import wmss_pkg::*; #(
  parameter int OFFSET_BITS = OffsetBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_module,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  section_id,
  output logic [31:0] start_offset,
  output logic [31:0] item_length,
  output logic [31:0] function_number,
  output logic        name_found,
  output logic        header_valid,
  output logic        last_result,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  logic [31:0] wanted_function;
  logic        take, r0v, r1v, room2;
  result_t     r0, r1, q;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_function <= '0;
    end else if (cfg_we) begin
      wanted_function <= cfg_data;
    end
  end

  assign in_ready = room2;
  assign take     = in_valid && in_ready;

  wmss_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk, .rst, .take, .data_byte, .end_of_module, .wanted_function,
    .res0_valid(r0v), .res1_valid(r1v), .res0(r0), .res1(r1)
  );

  wmss_queue u_queue (
    .clk, .rst,
    .push0(take && r0v), .push1(take && r1v),
    .din0(r0), .din1(r1), .room2,
    .out_valid, .dout(q), .out_ready
  );

  assign kind            = q.kind;
  assign section_id      = q.section_id;
  assign start_offset    = q.start_offset;
  assign item_length     = q.item_length;
  assign function_number = q.function_number;
  assign name_found      = q.name_found;
  assign header_valid    = q.header_valid;
  assign last_result     = q.last_result;

endmodule
